### src/tcw_pkg.sv
// tcw_pkg: shared types, constants and field widths for the text console writer
// depends on nothing; the other files of the block, all but tcw_ram, refer to it by scoped names

package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // field widths of the item and result channels
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    // attribute after reset: white on black
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // character bytes with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic item_load;     // latch the accepted item, clear result fields
        logic put_go;        // cursor update and cell write for a put
        logic clear_go;      // home cursor, start a blanking sweep
        logic read_go;       // issue the screen read for a read op
        logic sweep_run;     // advance the move / blank sweep by one cell
        logic read_capture;  // keep the returned cell
        logic out_load;      // load the output register
    } t_ctl_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic is_read;
        logic read_ok;       // read index lies inside the screen
        logic put_scrolls;   // this put pushes the cursor past the last row
        logic sweep_last;    // sweep is writing its last cell
    } t_dp_status;

endpackage

### src/tcw_item_if.sv
// tcw_item_if: valid/ready channel that carries one console operation
// depends on tcw_pkg for the field widths

interface tcw_item_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::OP_W-1:0]    op;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::IDX_W-1:0]   cell_index;

    modport source (output valid, output op, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input op, input char_code, input cell_index,
                    output ready);
endinterface

### src/tcw_result_if.sv
// tcw_result_if: valid/ready channel that carries one console result
// depends on tcw_pkg for the field widths

interface tcw_result_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::POS_W-1:0]   cursor_position;
    logic [tcw_pkg::CELL_W-1:0]  cell_value;
    logic                        did_scroll;

    modport source (output valid, output cursor_position, output cell_value,
                    output did_scroll, input ready);
    modport sink   (input valid, input cursor_position, input cell_value,
                    input did_scroll, output ready);
endinterface

### src/tcw_ram.sv
// tcw_ram: generic simple dual-port RAM, one write and one registered read port
// depends on nothing

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/tcw_datapath.sv
// tcw_datapath: cursor, attribute, sweep counter, screen RAM and result registers
// depends on tcw_pkg and tcw_ram

module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item payload
    input  logic [tcw_pkg::OP_W-1:0]    i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]   i_cell_index,
    // attribute register write
    input  logic                        i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wr_data,
    // controller link
    input  tcw_pkg::t_ctl_cmd           i_cmd,
    output tcw_pkg::t_dp_status         o_status,
    // result payload
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_value,
    output logic                        o_did_scroll
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = $clog2(ROWS);
    localparam int CLW        = $clog2(COLUMNS);
    localparam int SW         = $clog2(CELL_COUNT + 1);
    localparam int MOVE_END   = CELL_COUNT - COLUMNS;

    // latched item
    logic [tcw_pkg::OP_W-1:0]   r_op;
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic [tcw_pkg::IDX_W-1:0]  r_idx;

    // cursor, attribute, sweep
    logic [RW-1:0]              r_row, n_row;
    logic [CLW-1:0]             r_col, n_col;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [SW-1:0]              r_sweep;
    logic                       r_sweep_scroll;

    // result fields and output register
    logic [tcw_pkg::CELL_W-1:0] r_value;
    logic                       r_scrolled;
    logic [tcw_pkg::POS_W-1:0]  r_out_pos;
    logic [tcw_pkg::CELL_W-1:0] r_out_value;
    logic                       r_out_scroll;

    logic                       w_nl, w_bs, w_col_last, w_row_last;
    logic [RW-1:0]              w_tgt_row;
    logic [CLW-1:0]             w_tgt_col;
    logic [AW-1:0]              w_tgt_addr;
    logic [SW:0]                w_src_sum;
    logic                       w_move_rd, w_move_wr;
    logic [tcw_pkg::CELL_W-1:0] w_blank;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    // item decode
    assign w_nl       = (r_char == tcw_pkg::CH_NEWLINE);
    assign w_bs       = (r_char == tcw_pkg::CH_BACKSPACE);
    assign w_col_last = (r_col == CLW'(COLUMNS - 1));
    assign w_row_last = (r_row == RW'(ROWS - 1));
    assign w_blank    = {r_attr, tcw_pkg::CH_BLANK};

    assign o_status.is_put      = (r_op == tcw_pkg::OP_PUT);
    assign o_status.is_clear    = (r_op == tcw_pkg::OP_CLEAR);
    assign o_status.is_read     = (r_op == tcw_pkg::OP_READ);
    assign o_status.read_ok     = (32'(r_idx) < CELL_COUNT);
    assign o_status.put_scrolls = (w_nl || (!w_bs && w_col_last)) && w_row_last;
    assign o_status.sweep_last  = (r_sweep == SW'(CELL_COUNT));

    // next cursor for a put; the row saturates at the bottom, the sweep moves the rows
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (w_nl) begin
            n_col = '0;
            if (!w_row_last) begin
                n_row = r_row + 1'b1;
            end
        end else if (w_bs) begin
            if (r_col != '0) begin
                n_col = r_col - 1'b1;
            end else if (r_row != '0) begin
                n_row = r_row - 1'b1;
                n_col = CLW'(COLUMNS - 1);
            end
        end else if (w_col_last) begin
            n_col = '0;
            if (!w_row_last) begin
                n_row = r_row + 1'b1;
            end
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    // backspace blanks the cell it steps back onto; other cases use the cursor
    assign w_tgt_row  = (i_cmd.put_go && w_bs) ? n_row : r_row;
    assign w_tgt_col  = (i_cmd.put_go && w_bs) ? n_col : r_col;
    assign w_tgt_addr = AW'(AW'(w_tgt_row) * AW'(COLUMNS)) + AW'(w_tgt_col);

    // sweep: read the cell one row below, write it in the following cycle
    assign w_src_sum = {1'b0, r_sweep} + (SW + 1)'(COLUMNS);
    assign w_move_rd = (32'(r_sweep) < MOVE_END);
    assign w_move_wr = r_sweep_scroll && (32'(r_sweep) <= MOVE_END);

    // screen RAM port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = w_tgt_addr;
        ram_wdata = w_blank;
        ram_raddr = '0;
        if (i_cmd.put_go) begin
            ram_we    = !w_nl;
            ram_wdata = w_bs ? w_blank : {r_attr, r_char};
        end else if (i_cmd.sweep_run) begin
            ram_we    = (r_sweep != '0);
            ram_waddr = AW'(r_sweep - 1'b1);
            ram_wdata = w_move_wr ? ram_rdata : w_blank;
            ram_raddr = w_move_rd ? AW'(w_src_sum) : '0;
        end
        if (i_cmd.read_go) begin
            ram_raddr = AW'(r_idx);
        end
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // cursor, attribute and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_attr  <= tcw_pkg::ATTR_RESET;
            r_sweep <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
            if (i_cmd.put_go) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_sweep <= '0;
            end else if (i_cmd.clear_go) begin
                r_row   <= '0;
                r_col   <= '0;
                r_sweep <= '0;
            end else if (i_cmd.sweep_run) begin
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    // item latch, result fields and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_op       <= i_op;
            r_char     <= i_char_code;
            r_idx      <= i_cell_index;
            r_value    <= '0;
            r_scrolled <= 1'b0;
        end
        if (i_cmd.put_go) begin
            r_scrolled     <= o_status.put_scrolls;
            r_sweep_scroll <= 1'b1;
        end
        if (i_cmd.clear_go) begin
            r_sweep_scroll <= 1'b0;
        end
        if (i_cmd.read_capture) begin
            r_value <= ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_pos    <= tcw_pkg::POS_W'(w_tgt_addr);
            r_out_value  <= r_value;
            r_out_scroll <= r_scrolled;
        end
    end

    assign o_cursor_position = r_out_pos;
    assign o_cell_value      = r_out_value;
    assign o_did_scroll      = r_out_scroll;

endmodule

### src/tcw_controller.sv
// tcw_controller: state machine that sequences one console operation at a time
// depends on tcw_pkg for the command and status structs

module tcw_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_ctl_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_READ   = 5'b00100,
        S_SWEEP  = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_status.is_put) begin
                    o_cmd.put_go = 1'b1;
                    n_state      = i_status.put_scrolls ? S_SWEEP : S_RESULT;
                end else if (i_status.is_clear) begin
                    o_cmd.clear_go = 1'b1;
                    n_state        = S_SWEEP;
                end else if (i_status.is_read && i_status.read_ok) begin
                    o_cmd.read_go = 1'b1;
                    n_state       = S_READ;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                o_cmd.read_capture = 1'b1;
                n_state            = S_RESULT;
            end
            S_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### src/text_console_writer.sv
// text_console_writer: top level of the character-cell console writer
// depends on tcw_pkg, tcw_item_if, tcw_result_if, tcw_controller, tcw_datapath

// Keeps a ROWS x COLUMNS screen of 16-bit cells (attribute byte above character
// byte) in one RAM, plus a cursor. Each item is one operation: put a character
// (newline, backspace or printable), clear the screen, or read one cell; each
// gives one result with the cursor position after the step. One item is worked
// at a time. A read of a screen cell passes through an extra read state before
// its result. A clear, or a put that pushes the cursor past the last row, sweeps
// the whole screen through the single write port of the screen RAM, one cell a
// cycle. The output register lets a new item in while the previous result waits.
// The attribute register may be written only while the block is idle.

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tcw_item_if.sink                   i_item,
    tcw_result_if.source               o_result,
    input  logic                       i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wr_data
);

    tcw_pkg::t_ctl_cmd   cmd;
    tcw_pkg::t_dp_status status;

    // sequencing
    tcw_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // cursor, screen store and result registers
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (i_item.op),
        .i_char_code       (i_item.char_code),
        .i_cell_index      (i_item.cell_index),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_cursor_position (o_result.cursor_position),
        .o_cell_value      (o_result.cell_value),
        .o_did_scroll      (o_result.did_scroll)
    );

endmodule

### src/tcw_checker.sv
// tcw_checker: port-level assertions for the console writer, bound to the top level
// depends on tcw_pkg and text_console_writer

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tcw_pkg::POS_W-1:0]   i_cursor_position,
    input logic [tcw_pkg::CELL_W-1:0]  i_cell_value,
    input logic                        i_did_scroll
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int POS_SPAN   = 1 << tcw_pkg::POS_W;
    localparam int LAST_ROW   = (ROWS - 1) * COLUMNS;

    // reset leaves no result behind
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // the cursor always lies on the screen
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (CELL_COUNT > POS_SPAN || 32'(i_cursor_position) < CELL_COUNT))
        else $error("cursor position beyond the screen");

    // a scroll comes only from a put: cursor on the bottom row, no cell returned
    a_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_did_scroll |->
            i_cell_value == '0 &&
            (CELL_COUNT > POS_SPAN || 32'(i_cursor_position) >= LAST_ROW))
        else $error("scroll result inconsistent");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_cursor_position (o_result.cursor_position),
    .i_cell_value      (o_result.cell_value),
    .i_did_scroll      (o_result.did_scroll)
);
